// File: rtl/indexed_sequence_store_top_macros.svh
// Assertion macros for the indexed sequence store
`ifndef INDEXED_SEQUENCE_STORE_TOP_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_TOP_MACROS_SVH

// check that a property holds at every clock edge out of reset
`define ISQ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition never occurs out of reset
`define ISQ_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/isq_pkg.sv
// Types and constants shared by the indexed sequence store
`default_nettype none

package isq_pkg;

	localparam logic [2:0] KIND_INSERT   = 3'd0;
	localparam logic [2:0] KIND_ERASE    = 3'd1;
	localparam logic [2:0] KIND_GET      = 3'd2;
	localparam logic [2:0] KIND_SET      = 3'd3;
	localparam logic [2:0] KIND_LENGTH   = 3'd4;
	localparam logic [2:0] KIND_CAPACITY = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int unsigned CAP_EMPTY = 1;
	localparam int unsigned CAP_FIRST = 2;

	typedef struct packed {
		logic [2:0]         kind;
		logic [8:0]         position;
		logic signed [31:0] item_value;
		logic [8:0]         erase_count;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] answer;
	} result_word_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_CAP,
		S_CLIP,
		S_ESRC,
		S_EMOV,
		S_ELEN,
		S_INS,
		S_INSV,
		S_GET
	} state_t;

endpackage

`default_nettype wire

// File: rtl/isq_ram.sv
// Generic RAM, one write port and one registered read port
`default_nettype none

module isq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/isq_alu.sv
// Shared add, subtract and compare unit of the sequencer
`default_nettype none

module isq_alu #(
	parameter int W = 10
) (
	input  wire isq_pkg::alu_op_t op,
	input  wire logic [W-1:0]     a,
	input  wire logic [W-1:0]     b,
	output logic      [W-1:0]     res,
	output logic                  lt
);

	import isq_pkg::*;

	logic [W:0]   sum;
	logic [W-1:0] b_eff;
	logic         cin;

	always_comb begin
		cin   = (op == ALU_SUB);
		b_eff = cin ? ~b : b;
		sum   = {1'b0, a} + {1'b0, b_eff} + (W+1)'(cin);
		res   = sum[W-1:0];
		lt    = cin & ~sum[W];
	end

endmodule

`default_nettype wire

// File: rtl/indexed_sequence_store_top.sv
// Top level: sequencer, shared compare unit and entry memory of the sequence store
// Length, set, unused kinds, empty capacity and any refused word finish in the check
// state; get adds a memory read, capacity doubles from two until it exceeds the length,
// insert moves entries up and erase moves entries past the erased span down, one entry per cycle.
// One word at a time: busy drops as done rises, so the next word can start then.
// Reset clears length and control; memory contents stay undefined until written.
`default_nettype none

module indexed_sequence_store_top #(
	parameter int DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire isq_pkg::cmd_word_t cmd,
	output logic                   busy,
	output logic                   done,
	output isq_pkg::result_word_t  result
);

	import isq_pkg::*;

`include "indexed_sequence_store_top_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = ((LW > 9) ? LW : 9) + 1;

	state_t         state_q, state_nxt;
	logic [2:0]     kind_q;
	logic [CW-1:0]  pos_q, cnt_q, rd_q, wr_q, cap_q;
	logic [31:0]    val_q;
	logic [LW-1:0]  len_q;
	logic           mv_v_s1;
	logic [AW-1:0]  mv_wa_s1;
	logic           done_q;
	result_word_t   result_q;

	alu_op_t        alu_op;
	logic [CW-1:0]  alu_a, alu_b, alu_res;
	logic           alu_lt, alu_zero;

	logic           full;
	logic           ram_re, ram_we, dwe;
	logic [AW-1:0]  ram_raddr, ram_waddr;
	logic [31:0]    ram_wdata, ram_rdata;
	logic           finish;
	logic [1:0]     fin_status;
	logic [31:0]    fin_answer;
	logic           cap_done;

	isq_alu #(.W(CW)) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res),
		.lt (alu_lt)
	);

	isq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign alu_zero = (alu_res == '0);
	assign full     = (len_q == LW'(DEPTH));
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign result   = result_q;

	assign ram_we    = mv_v_s1 | dwe;
	assign ram_waddr = mv_v_s1 ? mv_wa_s1 : AW'(pos_q);
	assign ram_wdata = mv_v_s1 ? ram_rdata : val_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_CHK;
				end
			end
			S_CHK: begin
				state_nxt = S_IDLE;
				case (kind_q)
					KIND_INSERT: begin
						if (!alu_lt && !full) state_nxt = S_INS;
					end
					KIND_ERASE: begin
						if (!alu_lt) state_nxt = S_CLIP;
					end
					KIND_GET: begin
						if (!(alu_lt || alu_zero)) state_nxt = S_GET;
					end
					KIND_CAPACITY: begin
						if (len_q != '0) state_nxt = S_CAP;
					end
					default: state_nxt = S_IDLE;
				endcase
			end
			S_CAP:  state_nxt = alu_lt ? S_IDLE : S_CAP;
			S_CLIP: state_nxt = S_ESRC;
			S_ESRC: state_nxt = S_EMOV;
			S_EMOV: state_nxt = alu_lt ? S_EMOV : S_ELEN;
			S_ELEN: state_nxt = S_IDLE;
			S_INS:  state_nxt = alu_lt ? S_INS : S_INSV;
			S_INSV: state_nxt = S_IDLE;
			S_GET:  state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		alu_op     = ALU_ADD;
		alu_a      = '0;
		alu_b      = '0;
		ram_re     = 1'b0;
		ram_raddr  = AW'(pos_q);
		dwe        = 1'b0;
		finish     = 1'b0;
		fin_status = ST_OK;
		fin_answer = '0;
		case (state_q)
			S_CHK: begin
				alu_op = ALU_SUB;
				alu_a  = CW'(len_q);
				alu_b  = pos_q;
				case (kind_q)
					KIND_INSERT: begin
						if (alu_lt) begin
							finish     = 1'b1;
							fin_status = ST_RANGE;
						end else if (full) begin
							finish     = 1'b1;
							fin_status = ST_FULL;
						end
					end
					KIND_ERASE: begin
						if (alu_lt) begin
							finish     = 1'b1;
							fin_status = ST_RANGE;
						end
					end
					KIND_GET: begin
						if (alu_lt || alu_zero) begin
							finish     = 1'b1;
							fin_status = ST_RANGE;
						end else begin
							ram_re = 1'b1;
						end
					end
					KIND_SET: begin
						finish = 1'b1;
						if (alu_lt || alu_zero) begin
							fin_status = ST_RANGE;
						end else begin
							dwe = 1'b1;
						end
					end
					KIND_LENGTH: begin
						finish     = 1'b1;
						fin_answer = 32'(len_q);
					end
					KIND_CAPACITY: begin
						if (len_q == '0) begin
							finish     = 1'b1;
							fin_answer = 32'(CAP_EMPTY);
						end
					end
					default: finish = 1'b1;
				endcase
			end
			S_CAP: begin
				alu_op = ALU_SUB;
				alu_a  = CW'(len_q);
				alu_b  = cap_q;
				if (alu_lt) begin
					finish     = 1'b1;
					fin_answer = 32'(cap_q);
				end
			end
			S_CLIP: begin
				alu_op = ALU_SUB;
				alu_a  = rd_q;
				alu_b  = cnt_q;
			end
			S_ESRC: begin
				alu_op = ALU_ADD;
				alu_a  = pos_q;
				alu_b  = cnt_q;
			end
			S_EMOV: begin
				alu_op = ALU_SUB;
				alu_a  = rd_q;
				alu_b  = CW'(len_q);
				if (alu_lt) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(rd_q);
				end
			end
			S_ELEN: begin
				alu_op = ALU_SUB;
				alu_a  = CW'(len_q);
				alu_b  = cnt_q;
				finish = 1'b1;
			end
			S_INS: begin
				alu_op = ALU_SUB;
				alu_a  = pos_q;
				alu_b  = rd_q;
				if (alu_lt) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(rd_q - CW'(1));
				end
			end
			S_INSV: begin
				alu_op = ALU_ADD;
				alu_a  = CW'(len_q);
				alu_b  = CW'(1);
				dwe    = 1'b1;
				finish = 1'b1;
			end
			S_GET: begin
				finish     = 1'b1;
				fin_answer = ram_rdata;
			end
			default: finish = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			mv_v_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= finish;
			mv_v_s1 <= ((state_q == S_EMOV) || (state_q == S_INS)) && alu_lt;
			if ((state_q == S_ELEN) || (state_q == S_INSV)) begin
				len_q <= LW'(alu_res);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.status <= fin_status;
			result_q.answer <= fin_answer;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q <= cmd.kind;
					pos_q  <= CW'(cmd.position);
					val_q  <= cmd.item_value;
					cnt_q  <= CW'(cmd.erase_count);
				end
			end
			S_CHK: begin
				cap_q <= CW'(CAP_FIRST);
				rd_q  <= (kind_q == KIND_INSERT) ? CW'(len_q) : alu_res;
			end
			S_CAP: begin
				if (!alu_lt) cap_q <= cap_q << 1;
			end
			S_CLIP: begin
				if (alu_lt) cnt_q <= rd_q;
			end
			S_ESRC: begin
				rd_q <= alu_res;
				wr_q <= pos_q;
			end
			S_EMOV: begin
				if (alu_lt) begin
					rd_q     <= rd_q + CW'(1);
					wr_q     <= wr_q + CW'(1);
					mv_wa_s1 <= AW'(wr_q);
				end
			end
			S_INS: begin
				if (alu_lt) begin
					rd_q     <= rd_q - CW'(1);
					mv_wa_s1 <= AW'(rd_q);
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	assign cap_done = done && (result.status == ST_OK) && (kind_q == KIND_CAPACITY);

	`ISQ_NEVER(a_len_bound, len_q > LW'(DEPTH), "length exceeds depth")
	`ISQ_NEVER(a_write_clash, mv_v_s1 && dwe, "move write collides with direct write")
	`ISQ_ASSERT(a_done_from_work, done |-> $past(state_q != S_IDLE), "result without work")
	`ISQ_ASSERT(a_cap_pow2, cap_done |-> $onehot(result.answer), "capacity not a power of two")

endmodule

`default_nettype wire
